// ===== rtl/sdfm_pkg.sv =====
package sdfm_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int VAL_W     = 20;
	localparam int FUNC_W    = 2;

	// command codes
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DEL  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DUMP = 2'd2;

	// per-cycle cell operation
	localparam logic [1:0] OP_HOLD = 2'd0;
	localparam logic [1:0] OP_PUSH = 2'd1;
	localparam logic [1:0] OP_DEL  = 2'd2;
	localparam logic [1:0] OP_ROT  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [VAL_W-1:0]  value;
	} cmd_beat_t;

	typedef struct packed {
		logic [VAL_W-1:0] out_value;
		logic             found;
		logic             is_empty;
		logic             full_drop;
		logic             last;
	} rsp_beat_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [VAL_W-1:0] key;
	} cell_ctl_t;

endpackage

// ===== rtl/sdfm_cell.sv =====
module sdfm_cell import sdfm_pkg::*; #(
	parameter int DEPTH = MAX_DEPTH,
	parameter int IDX   = 0,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  cell_ctl_t        ctl,
	input  logic [CW-1:0]    count,
	input  logic [VAL_W-1:0] prev_data,
	input  logic [VAL_W-1:0] next_data,
	input  logic [VAL_W-1:0] wrap_data,
	input  logic             hit_in,
	output logic             hit_out,
	output logic [VAL_W-1:0] data
);

	logic [VAL_W-1:0] data_q;
	logic             occupied;
	logic             is_tail;

	assign occupied = CW'(IDX) < count;
	assign is_tail  = count == CW'(IDX + 1);

	// first-match chain: once a match is seen, every cell below closes the gap
	assign hit_out = hit_in | (occupied & (data_q == ctl.key));
	assign data    = data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_PUSH: data_q <= prev_data;
			OP_DEL: begin
				if (hit_out) data_q <= next_data;
			end
			OP_ROT:  data_q <= is_tail ? wrap_data : next_data;
			default: data_q <= data_q;
		endcase
	end

endmodule

// ===== rtl/stack_delete_first_match_unit.sv =====
// Newest-first value store built as a row of cells.
// Command channel (cmd_valid/cmd_stall/cmd): func push, delete-first-match or
// dump, plus a 20-bit value. Response channel (rsp_valid/rsp_stall/rsp): one
// beat per push, delete or unused code; a dump gives one beat per stored entry
// (newest first) or a single is_empty beat when the store is empty. The last
// beat of every command carries last=1.
// Push and delete answer in the cycle after acceptance. A dump first enters
// the dumping state; each dump step then loads the entry in cell 0 into the
// output register and rotates the row, one entry per cycle unless rsp_stall.
// Push and delete are taken back to back while the receiver does not stall,
// all cells compare in parallel; the length of a dump is set by the rotation
// of the cell row through cell 0, and cmd_stall stays high until its last beat is loaded.
// A single output register holds each response beat; while the receiver
// stalls, it holds and the block stalls new commands.
// Reset clears the entry count and all control state; the store is empty.
module stack_delete_first_match_unit import sdfm_pkg::*; #(
	parameter int DEPTH = MAX_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_beat_t cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic             dumping_q;
	logic             rsp_valid_q;
	rsp_beat_t        rsp_q;

	cell_ctl_t        ctl;
	logic [VAL_W-1:0] data_w [DEPTH];
	logic             hit_w  [DEPTH+1];
	logic             cmd_take;
	logic             rsp_free;
	logic             dump_step;
	logic             full;
	logic             hit;
	logic             dump_last;

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = dumping_q || (rsp_valid_q && rsp_stall);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign dump_step = dumping_q && rsp_free;
	assign full      = count_q == CW'(DEPTH);
	assign hit       = hit_w[DEPTH];
	assign dump_last = CW'(idx_q + 1'b1) == count_q;

	// cell row control
	always_comb begin
		ctl.key = cmd.value;
		ctl.op  = OP_HOLD;
		if (dump_step) begin
			ctl.op = OP_ROT;
		end else if (cmd_take) begin
			if (cmd.func == FUNC_PUSH && !full) ctl.op = OP_PUSH;
			else if (cmd.func == FUNC_DEL && hit) ctl.op = OP_DEL;
		end
	end

	assign hit_w[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		sdfm_cell #(
			.DEPTH (DEPTH),
			.IDX   (i),
			.CW    (CW)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (count_q),
			.prev_data ((i == 0) ? cmd.value : data_w[(i == 0) ? 0 : i-1]),
			.next_data (data_w[(i == DEPTH-1) ? i : i+1]),
			.wrap_data (data_w[0]),
			.hit_in    (hit_w[i]),
			.hit_out   (hit_w[i+1]),
			.data      (data_w[i])
		);
	end

	// count, dump sequencing, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			dumping_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (dump_step) begin
				rsp_valid_q <= 1'b1;
				idx_q       <= CW'(idx_q + 1'b1);
				if (dump_last) dumping_q <= 1'b0;
			end else if (cmd_take) begin
				if (cmd.func == FUNC_DUMP && count_q != '0) begin
					dumping_q   <= 1'b1;
					idx_q       <= '0;
					rsp_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= 1'b1;
				end
				if (ctl.op == OP_PUSH) count_q <= CW'(count_q + 1'b1);
				if (ctl.op == OP_DEL)  count_q <= CW'(count_q - 1'b1);
			end else if (rsp_free) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (dump_step) begin
			rsp_q.out_value <= data_w[0];
			rsp_q.found     <= 1'b0;
			rsp_q.is_empty  <= 1'b0;
			rsp_q.full_drop <= 1'b0;
			rsp_q.last      <= dump_last;
		end else if (cmd_take) begin
			rsp_q.out_value <= '0;
			rsp_q.found     <= (cmd.func == FUNC_DEL) && hit;
			rsp_q.full_drop <= (cmd.func == FUNC_PUSH) && full;
			rsp_q.last      <= 1'b1;
			case (cmd.func)
				FUNC_PUSH: rsp_q.is_empty <= 1'b0;
				FUNC_DEL: begin
					rsp_q.is_empty <= hit ? (count_q == CW'(1)) : (count_q == '0);
				end
				default: rsp_q.is_empty <= count_q == '0;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/sdfm_checker.sv =====
module sdfm_checker import sdfm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input cmd_beat_t cmd,
	input logic      rsp_valid,
	input logic      rsp_stall,
	input rsp_beat_t rsp
);

	// stalled response beat holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response beat changed under stall");

	// a dump in progress keeps new commands out
	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> cmd_stall)
		else $error("command accepted during dump");

	// dump beats carry no flags
	a_dump_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |-> !rsp.found && !rsp.is_empty && !rsp.full_drop)
		else $error("flag set on dump beat");

	// found and full_drop come only from single-beat commands with zero value
	a_flag_beats: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.found || rsp.full_drop) |->
			rsp.last && rsp.out_value == '0 && !(rsp.found && rsp.full_drop))
		else $error("bad flag combination");

endmodule

bind stack_delete_first_match_unit sdfm_checker u_sdfm_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sdfm_pkg::*;

	// unused command code, answered as a no-op
	localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 16;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_beat_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_beat_t rsp;

	// shadow copy of the stack, entry 0 newest
	logic [VAL_W-1:0] shadow_entries [MAX_DEPTH];
	int               shadow_count = 0;
	rsp_beat_t        pending_rsp [$];

	int error_count = 0;
	int idle_cycles = 0;
	int burst_left  = 0;
	int stall_mode  = 0;
	int stall_left  = 0;
	rsp_beat_t want_beat;

	stack_delete_first_match_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// update the shadow stack and queue the beats this command must produce
	function automatic void apply_to_shadow(input cmd_beat_t c);
		rsp_beat_t r;
		int        hit_idx;
		r       = '0;
		r.last  = 1'b1;
		hit_idx = -1;
		case (c.func)
			FUNC_PUSH: begin
				if (shadow_count >= MAX_DEPTH) begin
					r.full_drop = 1'b1;
				end else begin
					for (int i = shadow_count; i > 0; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[0] = c.value;
					shadow_count++;
				end
				pending_rsp.push_back(r);
			end
			FUNC_DEL: begin
				for (int i = 0; i < shadow_count; i++)
					if (hit_idx < 0 && shadow_entries[i] == c.value)
						hit_idx = i;
				if (hit_idx >= 0) begin
					for (int i = hit_idx; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
					r.found = 1'b1;
				end
				r.is_empty = (shadow_count == 0);
				pending_rsp.push_back(r);
			end
			FUNC_DUMP: begin
				if (shadow_count == 0) begin
					r.is_empty = 1'b1;
					pending_rsp.push_back(r);
				end else begin
					for (int i = 0; i < shadow_count; i++) begin
						r.out_value = shadow_entries[i];
						r.last      = (i == shadow_count - 1);
						pending_rsp.push_back(r);
					end
				end
			end
			default: begin
				r.is_empty = (shadow_count == 0);
				pending_rsp.push_back(r);
			end
		endcase
	endfunction

	// one command beat; bursts of random length with random gaps between them
	task automatic send_cmd(input logic [FUNC_W-1:0] func, input logic [VAL_W-1:0] value);
		cmd_beat_t c;
		int        gap;
		c.func  = func;
		c.value = value;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				cmd_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		apply_to_shadow(c);
	endtask

	// value source: full random, extremes, or a small pool that makes duplicates
	function automatic logic [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2, 3:    return VAL_W'($urandom_range(0, 7));
			default: return VAL_W'($urandom);
		endcase
	endfunction

	// delete key: mostly something stored, else anything
	function automatic logic [VAL_W-1:0] pick_delete_key();
		if (shadow_count > 0 && $urandom_range(0, 9) < 7)
			return shadow_entries[$urandom_range(0, shadow_count - 1)];
		return pick_value();
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
	                                    input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endfunction

	// receiver stall pattern; the mode is picked anew after each run of random length
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 80);
		end
		stall_left--;
		case (stall_mode)
			0:       rsp_stall <= 1'b0;
			1:       rsp_stall <= ($urandom_range(0, 3) == 0);
			2:       rsp_stall <= ($urandom_range(0, 3) != 0);
			default: rsp_stall <= ((stall_left % 5) < 2);
		endcase
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response beat, expected none, actual %p", $time, rsp);
				error_count++;
			end else begin
				want_beat = pending_rsp.pop_front();
				check_field("out_value", want_beat.out_value, rsp.out_value);
				check_field("found", want_beat.found, rsp.found);
				check_field("is_empty", want_beat.is_empty, rsp.is_empty);
				check_field("full_drop", want_beat.full_drop, rsp.full_drop);
				check_field("last", want_beat.last, rsp.last);
			end
		end
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// commands against an empty store
	task automatic test_empty_store();
		send_cmd(FUNC_DUMP, '0);
		send_cmd(FUNC_DEL, 20'h00005);
		send_cmd(FUNC_NOP, '1);
		send_cmd(FUNC_DEL, '0);
	endtask

	// extremes, duplicates, miss, oldest and newest removal
	task automatic test_push_delete();
		send_cmd(FUNC_PUSH, '0);
		send_cmd(FUNC_PUSH, '1);
		send_cmd(FUNC_PUSH, 20'hAAAAA);
		send_cmd(FUNC_PUSH, 20'h55555);
		send_cmd(FUNC_PUSH, 20'h55555);
		send_cmd(FUNC_DUMP, '1);
		send_cmd(FUNC_DEL, 20'h55555);
		send_cmd(FUNC_DUMP, '0);
		send_cmd(FUNC_DEL, 20'h12345);
		send_cmd(FUNC_NOP, '0);
		send_cmd(FUNC_DEL, '0);
		send_cmd(FUNC_DEL, '1);
		send_cmd(FUNC_DEL, 20'hAAAAA);
		send_cmd(FUNC_DEL, 20'h55555);
		send_cmd(FUNC_DUMP, '0);
	endtask

	// fill to capacity, dropped pushes, full dump, then removals at both ends
	task automatic test_fill_and_drain();
		while (shadow_count < MAX_DEPTH)
			send_cmd(FUNC_PUSH, pick_value());
		send_cmd(FUNC_PUSH, '1);
		send_cmd(FUNC_PUSH, '0);
		send_cmd(FUNC_DUMP, '0);
		send_cmd(FUNC_NOP, VAL_W'($urandom));
		send_cmd(FUNC_DEL, shadow_entries[shadow_count - 1]);
		send_cmd(FUNC_DEL, shadow_entries[0]);
		send_cmd(FUNC_PUSH, VAL_W'($urandom));
		send_cmd(FUNC_DUMP, '0);
	endtask

	// random traffic in segments that grow, shrink or mix the store
	task automatic test_random_traffic();
		int seg_mode;
		int push_pct;
		int roll;
		seg_mode = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 8 == 0)
				seg_mode = $urandom_range(0, 2);
			push_pct = (seg_mode == 0) ? 80 : (seg_mode == 1) ? 20 : 50;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				send_cmd(FUNC_DUMP, VAL_W'($urandom));
			else if (roll < 11)
				send_cmd(FUNC_NOP, VAL_W'($urandom));
			else if ($urandom_range(0, 99) < push_pct)
				send_cmd(FUNC_PUSH, pick_value());
			else
				send_cmd(FUNC_DEL, pick_delete_key());
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_store();
		test_push_delete();
		test_fill_and_drain();
		test_random_traffic();

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
